// ===== rtl/core/oqkm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqkm_pkg - shared types for the ordered queue with key match
// Request codes, status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package oqkm_pkg;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_DROP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_addr;
        logic [31:0] out_handle;
        logic [4:0]  match_count;
        logic        match_found;
        logic [4:0]  occupancy;
    } t_result;

endpackage

// ===== rtl/core/oqkm_resp_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqkm_resp_reg - result output register
// Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module oqkm_resp_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  oqkm_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output oqkm_pkg::t_result o_data
);

    logic              r_valid;
    oqkm_pkg::t_result r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== rtl/core/ordered_queue_with_key_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_queue_with_key_match - ordered queue with search and removal by key
// Entries (destination, handle) live in one synchronous memory in arrival
// order. A controller scans and compacts the memory one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+--------------------------------
//  request   | in        | i_valid / o_ready   | action, dest_addr, packet_handle,
//            |           |                     | position
//  result    | out       | o_valid / i_ready   | status, out_addr, out_handle,
//            |           |                     | match_count, match_found,
//            |           |                     | occupancy
//
//  Sequence: an enqueue or an out-of-range drop passes through S_EXEC and
//  S_RESP to the result register. Dequeue and query scan the stored entries
//  through the memory read port; a dequeue hit stops the scan there. A
//  removal then compacts the entries behind it through the read/write port
//  pair. After S_RESP the controller returns to S_IDLE for the next request.
//  Reset: synchronous active low; clears the fill count and control only,
//  slot memory contents are left as they are.
//  Stalls: a new request is taken once the previous result sits in the output
//  register, even while the consumer holds i_ready low.
// ----------------------------------------------------------------------------
module ordered_queue_with_key_match #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_packet_handle,
    input  logic [3:0]  i_position,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_addr,
    output logic [31:0] o_out_handle,
    output logic [4:0]  o_match_count,
    output logic        o_match_found,
    output logic [4:0]  o_occupancy
);

    // fill counter must hold DEPTH itself; memory address only DEPTH-1
    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (FW > 4) ? FW : 4;

    // ------------------------------------------------------------------
    // Slot memory: address in the high half, handle in the low half
    // ------------------------------------------------------------------
    logic [63:0]   r_slots [0:DEPTH-1];
    logic [63:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_slots[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    oqkm_pkg::t_state  r_state,   n_state;
    oqkm_pkg::t_action r_act,     n_act;
    logic [31:0]       r_addr,    n_addr;
    logic [31:0]       r_handle,  n_handle;
    logic [3:0]        r_pos,     n_pos;
    logic [FW-1:0]     r_fill,    n_fill;
    logic [FW-1:0]     r_rd_idx,  n_rd_idx;   // next memory index to read
    logic [FW-1:0]     r_chk_idx, n_chk_idx;  // index of the data in r_rdata
    logic              r_pend,    n_pend;     // r_rdata holds a live read
    logic [FW-1:0]     r_cnt,     n_cnt;
    oqkm_pkg::t_result r_res,     n_res;

    logic              res_valid;
    logic              res_ready;
    oqkm_pkg::t_result res_data;
    oqkm_pkg::t_result out_data;
    logic              hit;
    logic [FW-1:0]     wr_idx;

    assign o_ready = (r_state == oqkm_pkg::S_IDLE);
    assign hit     = r_pend && (r_rdata[63:32] == r_addr);
    assign wr_idx  = r_chk_idx - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oqkm_pkg::S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_addr    <= n_addr;
        r_handle  <= n_handle;
        r_pos     <= n_pos;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_addr    = r_addr;
        n_handle  = r_handle;
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_rd_idx  = r_rd_idx;
        n_chk_idx = r_chk_idx;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = wr_idx[AW-1:0];
        mem_wdata = r_rdata;
        mem_raddr = r_rd_idx[AW-1:0];
        res_valid = 1'b0;

        unique case (r_state)
            oqkm_pkg::S_IDLE: begin
                // hold the request for the whole operation
                if (i_valid) begin
                    n_act    = oqkm_pkg::t_action'(i_action);
                    n_addr   = i_dest_addr;
                    n_handle = i_packet_handle;
                    n_pos    = i_position;
                    n_state  = oqkm_pkg::S_EXEC;
                end
            end

            oqkm_pkg::S_EXEC: begin
                n_res    = '0;
                n_rd_idx = '0;
                n_pend   = 1'b0;
                n_cnt    = '0;
                unique case (r_act) inside
                    oqkm_pkg::ACT_ENQUEUE: begin
                        // append at the tail unless full
                        if (r_fill >= FW'(DEPTH)) begin
                            n_res.status = oqkm_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_fill[AW-1:0];
                            mem_wdata = {r_addr, r_handle};
                            n_fill    = r_fill + 1'b1;
                        end
                        n_state = oqkm_pkg::S_RESP;
                    end
                    oqkm_pkg::ACT_DEQUEUE, oqkm_pkg::ACT_QUERY: begin
                        n_state = oqkm_pkg::S_SCAN;
                    end
                    oqkm_pkg::ACT_DROP: begin
                        if (CW'(r_pos) >= CW'(r_fill)) begin
                            n_res.status = oqkm_pkg::ST_RANGE;
                            n_state      = oqkm_pkg::S_RESP;
                        end else begin
                            // close the gap starting from the entry after it
                            n_rd_idx = FW'(r_pos) + 1'b1;
                            n_state  = oqkm_pkg::S_SHIFT;
                        end
                    end
                    default: n_state = oqkm_pkg::S_RESP;
                endcase
            end

            oqkm_pkg::S_SCAN: begin
                if (hit && (r_act == oqkm_pkg::ACT_DEQUEUE)) begin
                    // first match: capture it and drop the read in flight
                    n_res.status     = oqkm_pkg::ST_OK;
                    n_res.out_addr   = r_rdata[63:32];
                    n_res.out_handle = r_rdata[31:0];
                    n_rd_idx         = r_chk_idx + 1'b1;
                    n_pend           = 1'b0;
                    n_state          = oqkm_pkg::S_SHIFT;
                end else begin
                    if (hit) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (r_rd_idx < r_fill) begin
                        n_pend    = 1'b1;
                        n_chk_idx = r_rd_idx;
                        n_rd_idx  = r_rd_idx + 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            if (r_act == oqkm_pkg::ACT_DEQUEUE) begin
                                n_res.status = oqkm_pkg::ST_NO_MATCH;
                            end else begin
                                n_res.status      = oqkm_pkg::ST_OK;
                                n_res.match_count = 5'(r_cnt);
                                n_res.match_found = (r_cnt != '0);
                            end
                            n_state = oqkm_pkg::S_RESP;
                        end
                    end
                end
            end

            oqkm_pkg::S_SHIFT: begin
                // move each entry one place toward the head
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_rd_idx < r_fill) begin
                    n_pend    = 1'b1;
                    n_chk_idx = r_rd_idx;
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_fill  = r_fill - 1'b1;
                        n_state = oqkm_pkg::S_RESP;
                    end
                end
            end

            oqkm_pkg::S_RESP: begin
                // hand the result to the output register
                res_valid = 1'b1;
                if (res_ready) begin
                    n_state = oqkm_pkg::S_IDLE;
                end
            end

            default: n_state = oqkm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        res_data           = r_res;
        res_data.occupancy = 5'(r_fill);
    end

    oqkm_resp_reg u_resp_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_status      = out_data.status;
    assign o_out_addr    = out_data.out_addr;
    assign o_out_handle  = out_data.out_handle;
    assign o_match_count = out_data.match_count;
    assign o_match_found = out_data.match_found;
    assign o_occupancy   = out_data.occupancy;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count exceeds depth");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == oqkm_pkg::S_EXEC || r_state == oqkm_pkg::S_SHIFT))
        else $error("slot write outside enqueue or compaction");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fill) |-> (r_fill == FW'($past(r_fill) + 1'b1)
                              || r_fill == FW'($past(r_fill) - 1'b1)))
        else $error("fill count moved by more than one");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == oqkm_pkg::S_EXEC))
        else $error("accepted request not executed");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the ordered queue with key match
// Drives enqueue, dequeue, query and drop requests through the valid/ready
// request channel and predicts every result from a private copy of the
// queue. A short directed pass covers empty, full, out-of-range and
// all-match cases. Random traffic follows, with idle and stall patterns on
// both channels and long result-side hold-offs that back up the request side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUEUE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
    localparam int KEY_COUNT    = 6;

    // ------------------------------------------------------------------------
    // Shadow queue: holds the expected contents and the results still owed
    // ------------------------------------------------------------------------
    class queue_scoreboard;
        bit [63:0]         entries[$];    // {dest_addr, packet_handle}, oldest first
        oqkm_pkg::t_result owed[$];
        int                errors;
        int                n_checked;
        int                n_action[4];
        int                n_status[4];

        function new();
            errors    = 0;
            n_checked = 0;
            foreach (n_action[k]) n_action[k] = 0;
            foreach (n_status[k]) n_status[k] = 0;
        endfunction

        // Apply one accepted request to the shadow queue and owe its result.
        function void note_request(oqkm_pkg::t_action act, logic [31:0] addr,
                                   logic [31:0] handle, logic [3:0] pos);
            oqkm_pkg::t_result r;
            int                hits;
            bit                done;
            r      = '0;
            hits   = 0;
            done   = 1'b0;
            r.status = oqkm_pkg::ST_OK;
            case (act)
                oqkm_pkg::ACT_ENQUEUE: begin
                    if (entries.size() >= QUEUE_DEPTH) r.status = oqkm_pkg::ST_FULL;
                    else entries.insert(entries.size(), {addr, handle});
                end
                oqkm_pkg::ACT_DEQUEUE: begin
                    r.status = oqkm_pkg::ST_NO_MATCH;
                    for (int k = 0; k < entries.size() && !done; k++) begin
                        if (entries[k][63:32] == addr) begin
                            r.out_addr   = entries[k][63:32];
                            r.out_handle = entries[k][31:0];
                            r.status     = oqkm_pkg::ST_OK;
                            entries.delete(k);
                            done = 1'b1;
                        end
                    end
                end
                oqkm_pkg::ACT_QUERY: begin
                    foreach (entries[k])
                        if (entries[k][63:32] == addr) hits++;
                    r.match_count = hits[4:0];
                    r.match_found = (hits != 0);
                end
                default: begin
                    if (int'(pos) >= entries.size()) r.status = oqkm_pkg::ST_RANGE;
                    else entries.delete(int'(pos));
                end
            endcase
            r.occupancy = 5'(entries.size());
            n_action[int'(act)]++;
            n_status[int'(r.status)]++;
            owed.insert(owed.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Match one accepted result against the oldest owed one.
        function void check_result(oqkm_pkg::t_result got);
            oqkm_pkg::t_result want;
            if (owed.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            n_checked++;
            compare_field("status",      32'(want.status),      32'(got.status));
            compare_field("out_addr",    want.out_addr,         got.out_addr);
            compare_field("out_handle",  want.out_handle,       got.out_handle);
            compare_field("match_count", 32'(want.match_count), 32'(got.match_count));
            compare_field("match_found", 32'(want.match_found), 32'(got.match_found));
            compare_field("occupancy",   32'(want.occupancy),   32'(got.occupancy));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [31:0] i_dest_addr;
    logic [31:0] i_packet_handle;
    logic [3:0]  i_position;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [31:0] o_out_addr;
    logic [31:0] o_out_handle;
    logic [4:0]  o_match_count;
    logic        o_match_found;
    logic [4:0]  o_occupancy;

    queue_scoreboard board = new();

    // Idle percentages per channel, changed by the stimulus between phases.
    int send_idle_pct = 27;
    int recv_idle_pct = 54;
    int cycle_count   = 0;

    logic [31:0] key_pool[KEY_COUNT];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ordered_queue_with_key_match #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_dest_addr     (i_dest_addr),
        .i_packet_handle (i_packet_handle),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_out_addr      (o_out_addr),
        .o_out_handle    (o_out_handle),
        .o_match_count   (o_match_count),
        .o_match_found   (o_match_found),
        .o_occupancy     (o_occupancy)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Idle cycles
    // drop valid first; valid is never lowered and raised in the same step,
    // so back-to-back requests keep it high across the boundary.
    task automatic send_request(oqkm_pkg::t_action act, logic [31:0] addr,
                                logic [31:0] handle, logic [3:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_dest_addr     <= addr;
        i_packet_handle <= handle;
        i_position      <= pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(act, addr, handle, pos);
    endtask

    // Random traffic. Alternate filling and draining tides so the queue
    // swings between empty and full; most addresses come from a small key
    // pool so dequeues and queries actually hit stored entries.
    task automatic send_random(int count);
        int unsigned       roll;
        bit                filling;
        oqkm_pkg::t_action act;
        logic [31:0]       addr;
        filling = 1'b1;
        foreach (key_pool[k]) key_pool[k] = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) filling = ~filling;
            roll = $urandom_range(99);
            if (filling)
                act = roll < 55 ? oqkm_pkg::ACT_ENQUEUE :
                      roll < 75 ? oqkm_pkg::ACT_DEQUEUE :
                      roll < 88 ? oqkm_pkg::ACT_QUERY : oqkm_pkg::ACT_DROP;
            else
                act = roll < 25 ? oqkm_pkg::ACT_ENQUEUE :
                      roll < 60 ? oqkm_pkg::ACT_DEQUEUE :
                      roll < 75 ? oqkm_pkg::ACT_QUERY : oqkm_pkg::ACT_DROP;
            addr = ($urandom_range(99) < 80) ? key_pool[$urandom_range(KEY_COUNT - 1)]
                                              : $urandom;
            send_request(act, addr, $urandom, 4'($urandom_range(15)));
        end
    endtask

    initial begin : stimulus
        logic [31:0] key_a;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_action        <= oqkm_pkg::ACT_ENQUEUE;
        i_dest_addr     <= '0;
        i_packet_handle <= '0;
        i_position      <= '0;
        key_a = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operations on an empty queue.
        send_request(oqkm_pkg::ACT_QUERY,   32'h0000_0000, 32'h0, 4'd0);
        send_request(oqkm_pkg::ACT_DEQUEUE, 32'hFFFF_FFFF, 32'h0, 4'd0);
        send_request(oqkm_pkg::ACT_DROP,    32'h0,         32'h0, 4'd0);
        // Fill to the brim with one key, handles at both extremes.
        send_request(oqkm_pkg::ACT_ENQUEUE, key_a, 32'h0000_0000, 4'd0);
        for (int k = 1; k < QUEUE_DEPTH - 1; k++)
            send_request(oqkm_pkg::ACT_ENQUEUE, key_a, $urandom, 4'd0);
        send_request(oqkm_pkg::ACT_ENQUEUE, key_a, 32'hFFFF_FFFF, 4'd0);
        // Refused enqueue, all-match query, then removals.
        send_request(oqkm_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_request(oqkm_pkg::ACT_QUERY,   key_a, 32'h0, 4'd0);
        send_request(oqkm_pkg::ACT_DEQUEUE, key_a, 32'h0, 4'd0);
        send_request(oqkm_pkg::ACT_DROP,    32'h0, 32'h0, 4'd15);
        send_request(oqkm_pkg::ACT_DROP,    32'h0, 32'h0, 4'd0);
        send_request(oqkm_pkg::ACT_DEQUEUE, ~key_a, 32'h0, 4'd0);

        // Random phases with different idle patterns.
        send_random(500);
        send_idle_pct = 54;
        recv_idle_pct = 27;
        send_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(500);
        i_valid <= 1'b0;

        // Drain: wait for every owed result, then give stragglers time.
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d query, %0d drop",
                 board.n_checked, board.n_action[oqkm_pkg::ACT_ENQUEUE],
                 board.n_action[oqkm_pkg::ACT_DEQUEUE],
                 board.n_action[oqkm_pkg::ACT_QUERY], board.n_action[oqkm_pkg::ACT_DROP]);
        $display("outcomes: %0d ok, %0d refused full, %0d unmatched, %0d bad position",
                 board.n_status[oqkm_pkg::ST_OK], board.n_status[oqkm_pkg::ST_FULL],
                 board.n_status[oqkm_pkg::ST_NO_MATCH], board.n_status[oqkm_pkg::ST_RANGE]);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted result, then choose ready for the
    // next cycle. Twice in the run, hold ready low for a long stretch so the
    // output register fills and the request side backs up.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        oqkm_pkg::t_result got;
        int                hold_cycles;
        bit                held_early;
        bit                held_late;
        i_ready     <= 1'b0;
        hold_cycles = 0;
        held_early  = 1'b0;
        held_late   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got.status      = oqkm_pkg::t_status'(o_status);
                got.out_addr    = o_out_addr;
                got.out_handle  = o_out_handle;
                got.match_count = o_match_count;
                got.match_found = o_match_found;
                got.occupancy   = o_occupancy;
                board.check_result(got);
            end
            if (!held_early && board.n_checked >= 300) begin
                held_early  = 1'b1;
                hold_cycles = 400;
            end else if (!held_late && board.n_checked >= 1200) begin
                held_late   = 1'b1;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

endmodule
